// ===== sv/stbs_pkg.sv =====
// Shared types and item codes for the sort-then-binary-search unit.
package stbs_pkg;

	typedef logic [1:0]         mode_t;
	typedef logic signed [31:0] elem_t;
	typedef logic [7:0]         pos_t;
	typedef logic [3:0]         probes_t;

	localparam mode_t MODE_LOAD  = 2'd0;
	localparam mode_t MODE_QUERY = 2'd1;
	localparam mode_t MODE_CLEAR = 2'd2;

	localparam probes_t PROBES_MAX = 4'd15;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

// ===== sv/stbs_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
interface stbs_in_if;
	logic           valid;
	logic           ready;
	stbs_pkg::mode_t mode;
	stbs_pkg::elem_t value;

	modport source (output valid, output mode, output value, input ready);
	modport sink   (input valid, input mode, input value, output ready);
endinterface

interface stbs_out_if;
	logic              valid;
	logic              ready;
	logic              found;
	stbs_pkg::pos_t    position;
	stbs_pkg::probes_t probe_count;

	modport source (output valid, output found, output position, output probe_count,
		input ready);
	modport sink   (input valid, input found, input position, input probe_count,
		output ready);
endinterface

// ===== sv/stbs_mem.sv =====
// Element store: one write port, one read port with registered read data.
module stbs_mem #(
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  stbs_pkg::elem_t            wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output stbs_pkg::elem_t            rdata
);
	import stbs_pkg::*;

	elem_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/stbs_cmp.sv =====
// Shared signed comparator used by both the sort and the search.
module stbs_cmp (
	input  stbs_pkg::elem_t    x,
	input  stbs_pkg::elem_t    y,
	output stbs_pkg::cmp_res_t res
);
	import stbs_pkg::*;

	always_comb begin
		res.lt = (x < y);
		res.eq = (x == y);
	end

endmodule

// ===== sv/sort_then_binary_search_unit.sv =====
// Top level: element store with in-place exchange sort and binary search.
//
// Request channel req carries mode and value; response channel rsp carries
// found, position and probe_count. Only a query produces a response.
// A load or a clear is taken while idle; req.ready stays high after it.
// A query drops req.ready until its response sits in the output register.
// On the first query after a load or a clear the store, if it holds two or
// more elements, is sorted in place, with one read and at most one write of
// the store per cycle through the single shared comparator.
// The search then runs each probe as an address step and then a compare on
// the registered read data, at most floor(log2 n)+1 probes; on a miss a last
// address step sees the bounds cross, and a response step loads the result,
// with req.ready high again once it is loaded.
// Reset empties the store logically (count and sorted flag clear, contents
// are left unknown) and drops any pending response.
// While rsp is stalled, loads and clears are still taken; a finished query
// waits with req.ready low until the held response has transferred.
module sort_then_binary_search_unit #(
	parameter int DEPTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	stbs_in_if.sink   req,
	stbs_out_if.source rsp
);
	import stbs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int BW = CW + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RDA   = 3'd1;
	localparam logic [2:0] ST_LDA   = 3'd2;
	localparam logic [2:0] ST_CMP   = 3'd3;
	localparam logic [2:0] ST_WRA   = 3'd4;
	localparam logic [2:0] ST_PROBE = 3'd5;
	localparam logic [2:0] ST_CHECK = 3'd6;
	localparam logic [2:0] ST_RESP  = 3'd7;

	logic [2:0]           state_q;
	logic [CW-1:0]        count_q;
	logic                 sorted_q;
	elem_t                key_q;
	elem_t                cur_q;
	logic [AW-1:0]        a_q;
	logic [AW-1:0]        b_q;
	logic signed [BW-1:0] lo_q;
	logic signed [BW-1:0] hi_q;
	logic [AW-1:0]        mid_q;
	probes_t              probes_q;
	logic                 found_q;
	logic                 rsp_valid_q;
	logic                 rsp_found_q;
	pos_t                 rsp_pos_q;
	probes_t              rsp_probes_q;

	logic                 accept;
	logic                 room;
	logic signed [BW:0]   sum_w;
	logic [AW-1:0]        mid_w;
	logic [CW-1:0]        b_next_w;
	logic                 last_b;
	logic                 last_a;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	elem_t                mem_wdata;
	logic [AW-1:0]        mem_raddr;
	elem_t                mem_rdata;
	elem_t                cmp_x;
	elem_t                cmp_y;
	cmp_res_t             cmp;

	stbs_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	stbs_cmp u_cmp (
		.x   (cmp_x),
		.y   (cmp_y),
		.res (cmp)
	);

	assign req.ready       = (state_q == ST_IDLE);
	assign accept          = req.valid && (state_q == ST_IDLE);
	assign room            = (count_q != CW'(DEPTH));
	assign sum_w           = {lo_q[BW-1], lo_q} + {hi_q[BW-1], hi_q};
	assign mid_w           = sum_w[AW:1];
	assign b_next_w        = CW'(b_q) + CW'(1);
	assign last_b          = (b_next_w == count_q);
	assign last_a          = ((CW'(a_q) + CW'(2)) >= count_q);

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.position    = rsp_pos_q;
	assign rsp.probe_count = rsp_probes_q;

	always_comb begin
		if (state_q == ST_CMP) begin
			cmp_x = mem_rdata;
			cmp_y = cur_q;
		end else begin
			cmp_x = key_q;
			cmp_y = mem_rdata;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = a_q;
		mem_wdata = cur_q;
		mem_raddr = a_q;
		case (state_q)
			ST_IDLE: begin
				mem_we    = accept && (req.mode == MODE_LOAD) && room;
				mem_waddr = count_q[AW-1:0];
				mem_wdata = req.value;
			end
			ST_RDA: begin
				mem_raddr = a_q;
			end
			ST_LDA: begin
				mem_raddr = b_q;
			end
			ST_CMP: begin
				mem_raddr = b_next_w[AW-1:0];
				mem_we    = cmp.lt;
				mem_waddr = b_q;
			end
			ST_WRA: begin
				mem_we    = 1'b1;
				mem_waddr = a_q;
			end
			ST_PROBE: begin
				mem_raddr = mid_w;
			end
			default: begin
				mem_raddr = mid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			sorted_q     <= 1'b0;
			key_q        <= '0;
			cur_q        <= '0;
			a_q          <= '0;
			b_q          <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			mid_q        <= '0;
			probes_q     <= '0;
			found_q      <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_found_q  <= 1'b0;
			rsp_pos_q    <= '0;
			rsp_probes_q <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready && (state_q != ST_RESP)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.mode)
							MODE_LOAD: begin
								if (room) begin
									count_q  <= count_q + CW'(1);
									sorted_q <= 1'b0;
								end
							end
							MODE_CLEAR: begin
								count_q  <= '0;
								sorted_q <= 1'b0;
							end
							MODE_QUERY: begin
								key_q    <= req.value;
								probes_q <= '0;
								found_q  <= 1'b0;
								lo_q     <= '0;
								hi_q     <= BW'(count_q) - BW'(1);
								sorted_q <= 1'b1;
								a_q      <= '0;
								if (!sorted_q && (count_q > CW'(1))) begin
									state_q <= ST_RDA;
								end else begin
									state_q <= ST_PROBE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RDA: begin
					b_q     <= a_q + AW'(1);
					state_q <= ST_LDA;
				end
				ST_LDA: begin
					cur_q   <= mem_rdata;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (cmp.lt) begin
						cur_q <= mem_rdata;
					end
					if (last_b) begin
						state_q <= ST_WRA;
					end else begin
						b_q <= b_q + AW'(1);
					end
				end
				ST_WRA: begin
					if (last_a) begin
						state_q <= ST_PROBE;
					end else begin
						a_q     <= a_q + AW'(1);
						state_q <= ST_RDA;
					end
				end
				ST_PROBE: begin
					if (lo_q <= hi_q) begin
						mid_q   <= mid_w;
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_CHECK: begin
					if (cmp.eq) begin
						found_q <= 1'b1;
						state_q <= ST_RESP;
					end else begin
						if (cmp.lt) begin
							hi_q <= BW'(mid_q) - BW'(1);
						end else begin
							lo_q <= BW'(mid_q) + BW'(1);
						end
						if (probes_q != PROBES_MAX) begin
							probes_q <= probes_q + 4'd1;
						end
						state_q <= ST_PROBE;
					end
				end
				ST_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_found_q  <= found_q;
						rsp_pos_q    <= found_q ? 8'(mid_q) : '0;
						rsp_probes_q <= probes_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/stbs_chk.sv =====
// Port-level checker for the sort-then-binary-search unit, with its bind.
module stbs_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input stbs_pkg::mode_t   req_mode,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic              rsp_found,
	input stbs_pkg::pos_t    rsp_position,
	input stbs_pkg::probes_t rsp_probe_count
);
	import stbs_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			$stable(rsp_found) && $stable(rsp_position) && $stable(rsp_probe_count))
		else $error("response payload changed while stalled");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_position == '0)
		else $error("position not zero on a miss");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_mode == MODE_QUERY) |=> !req_ready)
		else $error("request taken during a query");

endmodule

bind sort_then_binary_search_unit stbs_chk u_stbs_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_mode        (req.mode),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_found       (rsp.found),
	.rsp_position    (rsp.position),
	.rsp_probe_count (rsp.probe_count)
);

// ===== tb/stbs_checker.sv =====
`timescale 1ns / 100ps
// Checker: watches the request and response channels, predicts each lookup and compares.
module stbs_checker #(
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	stbs_in_if   req,
	stbs_out_if  rsp,
	output int   mismatches,
	output int   outstanding
);
	import stbs_pkg::*;

	typedef struct packed {
		logic    found;
		pos_t    position;
		probes_t probe_count;
	} lookup_t;

	elem_t   elements [DEPTH];
	int      n_elements;
	bit      in_order;
	lookup_t due_lookups [$];
	int      fails;

	task automatic sort_elements();
		elem_t t;
		for (int a = 0; a + 1 < n_elements; a++) begin
			for (int b = a + 1; b < n_elements; b++) begin
				if (elements[a] > elements[b]) begin
					t = elements[a];
					elements[a] = elements[b];
					elements[b] = t;
				end
			end
		end
	endtask

	function automatic lookup_t lookup_key(elem_t key);
		lookup_t r;
		int      lo;
		int      hi;
		int      mid;
		int      misses;
		r = '0;
		lo = 0;
		hi = n_elements - 1;
		misses = 0;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (elements[mid] == key) begin
				r.found = 1'b1;
				r.position = pos_t'(mid);
				break;
			end
			if (key < elements[mid])
				hi = mid - 1;
			else
				lo = mid + 1;
			if (misses < PROBES_MAX)
				misses++;
		end
		r.probe_count = probes_t'(misses);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_t want;
		if (!arst_n) begin
			n_elements = 0;
			in_order = 1'b0;
			due_lookups.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_lookups.size() == 0) begin
					fails++;
					$display("%0t: unexpected transfer: expected none, got %0b/%0d/%0d",
						$time, rsp.found, rsp.position, rsp.probe_count);
				end else begin
					want = due_lookups.pop_front();
					if (rsp.found !== want.found || rsp.position !== want.position ||
						rsp.probe_count !== want.probe_count) begin
						fails++;
						$display("%0t: mismatch: expected %0b/%0d/%0d, got %0b/%0d/%0d",
							$time, want.found, want.position, want.probe_count,
							rsp.found, rsp.position, rsp.probe_count);
					end
				end
			end
			if (req.valid && req.ready) begin
				case (req.mode)
					MODE_LOAD: begin
						if (n_elements < DEPTH) begin
							elements[n_elements] = req.value;
							n_elements++;
							in_order = 1'b0;
						end
					end
					MODE_QUERY: begin
						if (!in_order) begin
							sort_elements();
							in_order = 1'b1;
						end
						due_lookups.push_back(lookup_key(req.value));
					end
					MODE_CLEAR: begin
						n_elements = 0;
						in_order = 1'b0;
					end
					default: ;
				endcase
			end
		end
		mismatches <= fails;
		outstanding <= due_lookups.size();
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, request stimulus, response stalls and the verdict.
module tb;
	import stbs_pkg::*;

	localparam int    DEPTH       = 256;
	localparam mode_t MODE_UNUSED = 2'd3;
	localparam int    PHASE_ITEMS = 400;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   idle_pct;
	int   stall_pct;
	int   items_sent;
	int   loaded_total;
	int   idle_by_phase [4] = '{0, 78, 0, 32};
	int   stall_by_phase [4] = '{0, 0, 78, 32};

	stbs_in_if  req ();
	stbs_out_if rsp ();

	sort_then_binary_search_unit #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	stbs_checker #(.DEPTH(DEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#16_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send(mode_t m, elem_t v);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= m;
		req.value <= v;
		do @(posedge clk); while (!req.ready);
		if (m != MODE_UNUSED)
			items_sent++;
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic elem_t pick_value(bit narrow);
		if (narrow)
			return elem_t'($urandom_range(16)) - 8;
		case ($urandom_range(15))
			0:       return elem_t'(32'h8000_0000);
			1:       return elem_t'(32'h7fff_ffff);
			2:       return '0;
			3:       return '1;
			default: return elem_t'($urandom);
		endcase
	endfunction

	function automatic elem_t pick_key(elem_t pool[$], bit narrow);
		if (pool.size() != 0 && $urandom_range(9) < 6)
			return pool[$urandom_range(pool.size() - 1)];
		if (pool.size() != 0 && $urandom_range(3) == 0)
			return pool[$urandom_range(pool.size() - 1)] + ($urandom_range(1) ? 1 : -1);
		return pick_value(narrow);
	endfunction

	task automatic run_batch(bit fill);
		elem_t pool [$];
		elem_t v;
		int    n;
		int    nq;
		bit    narrow;
		if (fill || loaded_total > 40 || $urandom_range(9) < 8) begin
			send(MODE_CLEAR, elem_t'($urandom));
			loaded_total = 0;
		end
		narrow = ($urandom_range(9) < 3);
		if (fill)
			n = DEPTH + 4;
		else if ($urandom_range(9) == 0)
			n = $urandom_range(40, 17);
		else
			n = $urandom_range(12);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0)
				send(MODE_UNUSED, elem_t'($urandom));
			v = pick_value(narrow);
			pool.push_back(v);
			send(MODE_LOAD, v);
			loaded_total++;
		end
		nq = fill ? 20 : $urandom_range(8, 1);
		for (int i = 0; i < nq; i++)
			send(MODE_QUERY, pick_key(pool, narrow));
		if ($urandom_range(9) < 3) begin
			v = pick_value(narrow);
			pool.push_back(v);
			send(MODE_LOAD, v);
			loaded_total++;
			nq = $urandom_range(3, 1);
			for (int i = 0; i < nq; i++)
				send(MODE_QUERY, pick_key(pool, narrow));
		end
	endtask

	initial begin
		bit first;
		int goal;
		idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		loaded_total = 0;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.mode <= MODE_LOAD;
		req.value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(MODE_QUERY, elem_t'(32'h0000_0005));
		send(MODE_UNUSED, '1);
		send(MODE_LOAD, elem_t'(32'h7fff_ffff));
		send(MODE_LOAD, elem_t'(32'h8000_0000));
		send(MODE_LOAD, '0);
		send(MODE_LOAD, '1);
		send(MODE_LOAD, elem_t'(5));
		send(MODE_LOAD, elem_t'(5));
		send(MODE_QUERY, elem_t'(32'h8000_0000));
		send(MODE_QUERY, elem_t'(32'h7fff_ffff));
		send(MODE_QUERY, '1);
		send(MODE_QUERY, elem_t'(5));
		send(MODE_QUERY, elem_t'(4));
		send(MODE_QUERY, elem_t'(32'h7fff_fffe));
		send(MODE_LOAD, elem_t'(3));
		send(MODE_QUERY, elem_t'(3));
		send(MODE_CLEAR, elem_t'(32'h5555_aaaa));
		send(MODE_QUERY, '0);
		send(MODE_LOAD, elem_t'(7));
		send(MODE_QUERY, elem_t'(7));
		send(MODE_QUERY, elem_t'(8));
		send(MODE_QUERY, elem_t'(-8));
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			goal = items_sent + PHASE_ITEMS;
			first = 1'b1;
			while (items_sent < goal) begin
				run_batch(first && (ph % 2 == 0));
				first = 1'b0;
			end
			wait_idle();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/stbs_pkg.sv
sv/stbs_if.sv
sv/stbs_mem.sv
sv/stbs_cmp.sv
sv/sort_then_binary_search_unit.sv
sv/stbs_chk.sv
tb/stbs_checker.sv
tb/tb.sv
